// ===== src/qiks_pkg.sv =====
`timescale 1ns / 1ps

package qiks_pkg;

  // Window of earlier bytes; the longest keyword is seven characters
  localparam int WINDOW_DEPTH = 6;
  localparam int KW_MAX_LEN   = WINDOW_DEPTH + 1;

  // Keyword slots
  localparam int KW_COUNT = 5;
  localparam int KW_OR    = 0;
  localparam int KW_UNION = 1;
  localparam int KW_JOIN  = 2;
  localparam int KW_DASH  = 3;
  localparam int KW_SLASH = 4;

  localparam int KW_LEN [KW_COUNT] = '{4, 7, 6, 2, 2};

  // Keyword text, first character at index 0, padded with zero bytes
  localparam logic [7:0] KW_TABLE [KW_COUNT][KW_MAX_LEN] = '{
    '{" ", "O", "R", " ", 8'h00, 8'h00, 8'h00},
    '{" ", "U", "N", "I", "O", "N", " "},
    '{" ", "J", "O", "I", "N", " ", 8'h00},
    '{"-", "-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"/", "*", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [7:0] CHAR_SEMI = ";";
  localparam logic [7:0] CHAR_LC_A = "a";
  localparam logic [7:0] CHAR_LC_Z = "z";
  localparam logic [7:0] CASE_GAP  = 8'd32;

  // Only a..z are mapped; everything else passes unchanged
  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      r = c - CASE_GAP;
    end
    return r;
  endfunction

endpackage

// ===== src/qiks_in_if.sv =====
`timescale 1ns / 1ps

interface qiks_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] query_byte;
  logic       last_byte;

  modport source (output valid, output query_byte, output last_byte, input ready);
  modport sink   (input valid, input query_byte, input last_byte, output ready);
endinterface

// ===== src/qiks_out_if.sv =====
`timescale 1ns / 1ps

interface qiks_out_if;
  logic valid;
  logic ready;
  logic tautology_found;
  logic union_found;
  logic extra_statement_found;
  logic comment_found;
  logic query_passed;

  modport source (output valid, output tautology_found, output union_found,
                  output extra_statement_found, output comment_found,
                  output query_passed, input ready);
  modport sink   (input valid, input tautology_found, input union_found,
                  input extra_statement_found, input comment_found,
                  input query_passed, output ready);
endinterface

// ===== src/qiks_cell.sv =====
`timescale 1ns / 1ps

// One window position: holds an upper-cased byte, passes it on at each shift,
// and compares it with the keyword characters expected at its distance.
module qiks_cell
  import qiks_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic                clear,
  input  logic [7:0]          char_in,
  output logic [7:0]          char_out,
  output logic [KW_COUNT-1:0] char_eq
);

  logic [7:0] held;

  // Shift stage; cleared at the end of each query
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= '0;
    end else if (shift) begin
      held <= char_in;
    end
  end

  assign char_out = held;

  // Keyword characters this cell must see; positions past a keyword's start
  // do not take part
  for (genvar j = 0; j < KW_COUNT; j++) begin : g_kw
    if (POS + 1 < KW_LEN[j]) begin : g_cmp
      assign char_eq[j] = (held == KW_TABLE[j][KW_LEN[j] - 2 - POS]);
    end else begin : g_free
      assign char_eq[j] = 1'b1;
    end
  end

endmodule

// ===== src/query_injection_keyword_scanner_core.sv =====
`timescale 1ns / 1ps

// The result word appears in the cycle after the last byte is taken.
// Throughput: one byte per cycle while ready is high; the keyword compare across the six-cell
// window and the current byte completes within that cycle.
// Input stalls only while a result word waits and the sink holds ready low.
// Reset (synchronous, rst high) clears the window, sticky flags and output valid bit.
module query_injection_keyword_scanner_core
  import qiks_pkg::*;
(
  input logic      clk,
  input logic      rst,
  qiks_in_if.sink  query_in,
  qiks_out_if.source result_out
);

  logic                take;
  logic                finish;
  logic [7:0]          cur;
  logic                semi;
  logic [7:0]          window [WINDOW_DEPTH];
  logic [KW_COUNT-1:0] cell_eq [WINDOW_DEPTH];
  logic [KW_COUNT-1:0] cur_eq;
  logic [KW_COUNT-1:0] kw_hit;
  logic [3:0]          found;
  logic [3:0]          found_next;
  logic [1:0]          pending;
  logic [1:0]          bytes_seen;
  logic                out_valid;
  logic [3:0]          out_flags;

  // Handshake: take a byte whenever the output register is free or draining
  assign query_in.ready = !out_valid || result_out.ready;
  assign take   = query_in.valid && query_in.ready;
  assign finish = take && query_in.last_byte;

  assign cur  = upcase(query_in.query_byte);
  assign semi = (query_in.query_byte == CHAR_SEMI);

  // Window chain
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    logic [7:0] feed;
    if (k == 0) begin : g_head
      assign feed = cur;
    end else begin : g_link
      assign feed = window[k-1];
    end
    qiks_cell #(.POS(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (take),
      .clear    (finish),
      .char_in  (feed),
      .char_out (window[k]),
      .char_eq  (cell_eq[k])
    );
  end

  // Last character of each keyword against the current byte
  for (genvar j = 0; j < KW_COUNT; j++) begin : g_cur
    assign cur_eq[j] = (cur == KW_TABLE[j][KW_LEN[j] - 1]);
  end

  // Combine the cell compares
  always_comb begin
    kw_hit = cur_eq;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      kw_hit = kw_hit & cell_eq[k];
    end
  end

  // Sticky flags: bit0 tautology, bit1 union/join, bit2 extra statement, bit3 comment
  always_comb begin
    found_next = found;
    if (kw_hit[KW_OR]) begin
      found_next[0] = 1'b1;
    end
    if (kw_hit[KW_UNION] || kw_hit[KW_JOIN]) begin
      found_next[1] = 1'b1;
    end
    if (pending[1] || (query_in.last_byte && bytes_seen == 2'd0 && semi)) begin
      found_next[2] = 1'b1;
    end
    if (kw_hit[KW_DASH] || kw_hit[KW_SLASH]) begin
      found_next[3] = 1'b1;
    end
  end

  // Per-query state
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      found      <= '0;
      pending    <= '0;
      bytes_seen <= '0;
    end else if (take) begin
      found      <= found_next;
      pending    <= {pending[0], semi};
      if (bytes_seen != 2'd2) begin
        bytes_seen <= bytes_seen + 2'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_flags <= found_next;
    end
  end

  assign result_out.valid                 = out_valid;
  assign result_out.tautology_found       = out_flags[0];
  assign result_out.union_found           = out_flags[1];
  assign result_out.extra_statement_found = out_flags[2];
  assign result_out.comment_found         = out_flags[3];
  assign result_out.query_passed          = (out_flags == 4'd0);

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    finish |=> result_out.valid)
    else $error("no result word after last byte");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    finish |=> (found == 4'd0 && pending == 2'd0 && bytes_seen == 2'd0))
    else $error("query state not cleared after last byte");

  a_free_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> query_in.ready)
    else $error("input stalled while output register empty");

  a_pass_consistent: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (result_out.query_passed ==
      !(result_out.tautology_found || result_out.union_found ||
        result_out.extra_statement_found || result_out.comment_found)))
    else $error("pass bit disagrees with flags");
`endif

endmodule
